/* rtl/gmmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gmmc_pkg
// Shared constants for the grid motion mode controller: grid size default,
// register indexes and register reset values.
// ---------------------------------------------------------------------------
package gmmc_pkg;

    // default grid side and derived changed-cell count width
    localparam int GRID_SIDE_DEF = 16;
    localparam int COUNT_W_DEF   = $clog2(GRID_SIDE_DEF * GRID_SIDE_DEF) + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_IGNORE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERT_IGNORE  = 3'd4;

    // register reset values
    localparam logic [7:0] DIFF_THR_RST       = 8'd15;
    localparam int         COUNT_THR_RST      = 10;
    localparam logic [7:0] COOLDOWN_RST       = 8'd50;
    localparam logic [7:0] STARTUP_IGNORE_RST = 8'd10;
    localparam logic [7:0] REVERT_IGNORE_RST  = 8'd15;

endpackage : gmmc_pkg
`default_nettype wire

/* rtl/gmmc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gmmc_if
// Valid/ready channels of the grid motion mode controller: the sample item
// channel and the per-frame result item channel.
// ---------------------------------------------------------------------------

// sample item channel
interface gmmc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface : gmmc_in_if

// per-frame result item channel
interface gmmc_out_if #(
    parameter int COUNT_W = gmmc_pkg::COUNT_W_DEF
);
    logic               valid;
    logic               ready;
    logic               motion;
    logic [COUNT_W-1:0] changed_cells;
    logic               high_res;
    logic               send_frame;
    logic               ignoring;

    modport source (output valid, output motion, output changed_cells, output high_res,
                    output send_frame, output ignoring, input ready);
    modport sink   (input valid, input motion, input changed_cells, input high_res,
                    input send_frame, input ignoring, output ready);
endinterface : gmmc_out_if
`default_nettype wire

/* rtl/grid_motion_mode_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grid_motion_mode_controller
// Frame-difference motion detector over a square grid of byte samples with a
// sentry / high-res mode controller updated once per frame.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  samples   in   valid/ready        sample[7:0], frame_end
//  results   out  valid/ready        motion, changed_cells, high_res,
//                                    send_frame, ignoring
//  cfg       in   cfg_wr_en only     cfg_index, cfg_wdata
//
//  One sample item per cycle sustained; a sample goes through a two-stage
//  read / compare-write path on the single cell memory (one read port, one
//  write port), and a frame result is registered when its last item leaves
//  the compare stage. The cell memory is not swept at reset: a fill count
//  marks the prefix of cells written since reset, cells above it read as
//  zero. A waiting result stalls the next last item and the items behind it;
//  earlier items keep flowing. Reset is asynchronous, active low.
// ---------------------------------------------------------------------------
module grid_motion_mode_controller #(
    parameter  int GRID_SIDE  = gmmc_pkg::GRID_SIDE_DEF,
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE,
    localparam int CELL_BITS  = $clog2(CELL_COUNT),
    localparam int CNT_W      = CELL_BITS + 1,
    localparam int CFG_W      = (CNT_W > 8) ? CNT_W : 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gmmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_wdata,
    gmmc_in_if.sink                             samples,
    gmmc_out_if.source                          results
);
    import gmmc_pkg::*;

    // configuration registers
    logic [7:0]       diff_thr_reg;
    logic [CNT_W-1:0] count_thr_reg;
    logic [7:0]       cooldown_cfg_reg;
    logic [7:0]       revert_ignore_reg;

    // position counter in front of the memory
    logic [CNT_W-1:0] pos_reg;
    logic [CELL_BITS-1:0] in_addr;
    logic             in_ready;
    logic             in_fire;

    // compare stage
    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic                 s1_inrange_reg;
    logic [CELL_BITS-1:0] s1_addr_reg;
    logic [7:0]           s1_sample_reg;
    logic                 fwd_reg;
    logic [7:0]           fwd_data_reg;
    logic [7:0]           rdata_reg;
    logic [CNT_W-1:0]     fill_reg;

    // cell memory
    logic [7:0] mem [CELL_COUNT];
    logic       mem_we;

    // frame state
    logic             primed_reg, primed_next;
    logic             high_res_reg, high_res_next;
    logic [7:0]       cooldown_reg, cooldown_next;
    logic [7:0]       ignore_reg, ignore_next;
    logic [CNT_W-1:0] changed_count_reg, changed_count_next;

    // output register
    logic             out_valid_reg;
    logic             out_motion_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_high_res_reg;
    logic             out_send_reg;
    logic             out_ignoring_reg;

    // compare stage signals
    logic             active;
    logic             cmp_en;
    logic             entry_valid;
    logic [7:0]       old_val;
    logic [7:0]       abs_diff;
    logic             cell_changed;
    logic [CNT_W-1:0] count_sum;
    logic             s1_fire;
    logic             frame_done;
    logic             frame_motion;
    logic [CNT_W-1:0] frame_count;
    logic             frame_send;
    logic             frame_ignoring;

    // configuration writes; the startup window length only matters at reset,
    // so a write to it is taken and has no lasting effect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_thr_reg      <= DIFF_THR_RST;
            count_thr_reg     <= CNT_W'(COUNT_THR_RST);
            cooldown_cfg_reg  <= COOLDOWN_RST;
            revert_ignore_reg <= REVERT_IGNORE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DIFF_THR:       diff_thr_reg      <= cfg_wdata[7:0];
                CFG_COUNT_THR:      count_thr_reg     <= cfg_wdata[CNT_W-1:0];
                CFG_COOLDOWN:       cooldown_cfg_reg  <= cfg_wdata[7:0];
                CFG_STARTUP_IGNORE: ;
                CFG_REVERT_IGNORE:  revert_ignore_reg <= cfg_wdata[7:0];
                default:            ;
            endcase
        end
    end

    // handshake
    assign active     = primed_reg && !high_res_reg;
    assign cmp_en     = s1_valid_reg && s1_inrange_reg && active;
    assign s1_fire    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || results.ready);
    assign frame_done = s1_fire && s1_last_reg;
    assign mem_we     = s1_fire && cmp_en;
    assign in_ready   = !s1_valid_reg || s1_fire;
    assign in_fire    = samples.valid && in_ready;
    assign in_addr    = pos_reg[CELL_BITS-1:0];
    assign samples.ready = in_ready;

    // cell position, saturating past the last cell until frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (in_fire)
        begin
            if (samples.frame_end)
                pos_reg <= '0;
            else if (pos_reg < CNT_W'(CELL_COUNT))
                pos_reg <= pos_reg + CNT_W'(1);
        end
    end

    // memory: registered read on accept, write from the compare stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rdata_reg <= mem[in_addr];
        if (mem_we)
            mem[s1_addr_reg] <= s1_sample_reg;
    end

    // compare stage control and forwarding of a same-cell write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            fill_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= mem_we && (s1_addr_reg == in_addr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_we && ({1'b0, s1_addr_reg} >= fill_reg))
                fill_reg <= {1'b0, s1_addr_reg} + CNT_W'(1);
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_last_reg    <= samples.frame_end;
            s1_inrange_reg <= (pos_reg < CNT_W'(CELL_COUNT));
            s1_addr_reg    <= in_addr;
            s1_sample_reg  <= samples.sample;
            fwd_data_reg   <= s1_sample_reg;
        end
    end

    // absolute difference against the stored cell
    always_comb
    begin
        entry_valid  = ({1'b0, s1_addr_reg} < fill_reg);
        old_val      = fwd_reg ? fwd_data_reg : (entry_valid ? rdata_reg : 8'd0);
        abs_diff     = (s1_sample_reg > old_val) ? (s1_sample_reg - old_val)
                                                 : (old_val - s1_sample_reg);
        cell_changed = cmp_en && (abs_diff > diff_thr_reg);
        count_sum    = changed_count_reg + CNT_W'(cell_changed);
    end

    // per-frame mode update
    always_comb
    begin
        primed_next        = primed_reg;
        high_res_next      = high_res_reg;
        cooldown_next      = cooldown_reg;
        ignore_next        = ignore_reg;
        changed_count_next = changed_count_reg;
        frame_count        = active ? count_sum : '0;
        frame_motion       = active && (count_sum > count_thr_reg);
        frame_send         = 1'b1;
        frame_ignoring     = 1'b0;
        if (s1_fire)
            changed_count_next = count_sum;
        if (frame_done)
        begin
            changed_count_next = '0;
            if (ignore_reg != 8'd0)
            begin
                ignore_next    = ignore_reg - 8'd1;
                frame_ignoring = 1'b1;
                primed_next    = 1'b1;
            end
            else if (!high_res_reg)
            begin
                if (frame_motion)
                begin
                    high_res_next = 1'b1;
                    cooldown_next = cooldown_cfg_reg;
                    frame_send    = 1'b0;
                end
                primed_next = 1'b1;
            end
            else if (cooldown_reg <= 8'd1)
            begin
                cooldown_next = 8'd0;
                high_res_next = 1'b0;
                ignore_next   = revert_ignore_reg;
            end
            else
            begin
                cooldown_next = cooldown_reg - 8'd1;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg        <= 1'b0;
            high_res_reg      <= 1'b0;
            cooldown_reg      <= 8'd0;
            ignore_reg        <= STARTUP_IGNORE_RST;
            changed_count_reg <= '0;
        end
        else
        begin
            primed_reg        <= primed_next;
            high_res_reg      <= high_res_next;
            cooldown_reg      <= cooldown_next;
            ignore_reg        <= ignore_next;
            changed_count_reg <= changed_count_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (frame_done)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            out_motion_reg   <= frame_motion;
            out_count_reg    <= frame_count;
            out_high_res_reg <= high_res_next;
            out_send_reg     <= frame_send;
            out_ignoring_reg <= frame_ignoring;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.motion        = out_motion_reg;
    assign results.changed_cells = out_count_reg;
    assign results.high_res      = out_high_res_reg;
    assign results.send_frame    = out_send_reg;
    assign results.ignoring      = out_ignoring_reg;

    // no cell is written while in high-res mode or before priming
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (primed_reg && !high_res_reg))
        else $error("cell write outside active sentry mode");

    // fill count never runs past the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CELL_COUNT))
        else $error("fill count past last cell");

    // a new result only follows a completed last item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result without frame end item");

    // frame end restarts the cell position
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && samples.frame_end) |=> (pos_reg == '0))
        else $error("cell position not restarted after frame end");

endmodule : grid_motion_mode_controller
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the grid motion mode controller. A scripted run
// covers reset values, the startup ignore window, an unprimed frame, short
// frames, the difference threshold edge, a trigger with zero cooldown and the
// revert ignore window. Random phases follow, each with new register values,
// and send mostly short frames with a few full and overlong ones, with content
// chosen around the thresholds. Every frame result is checked field by field
// against the values given in its scripted row or an in-bench model of the
// detector and mode controller. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
    import gmmc_pkg::*;

    localparam int CELLS          = GRID_SIDE_DEF * GRID_SIDE_DEF;
    localparam int CNT_W          = COUNT_W_DEF;
    localparam int CFG_W          = (CNT_W > 8) ? CNT_W : 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEMS_GOAL     = 750;
    localparam int MAX_PRINTED    = 50;

    // one frame result item
    typedef struct packed {
        logic             motion;
        logic [CNT_W-1:0] changed_cells;
        logic             high_res;
        logic             send_frame;
        logic             ignoring;
    } frame_result_t;

    // one row of the scripted run: a register write or a sample item
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [7:0]           smp;
        logic                 last;
        bit                   typed;
        frame_result_t        want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    gmmc_in_if  in_ch ();
    gmmc_out_if out_ch ();

    grid_motion_mode_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .samples   (in_ch),
        .results   (out_ch)
    );

    // detector model state and register copies
    logic [7:0]       cell_store [CELLS];
    bit               primed        = 1'b0;
    int               cell_pos      = 0;
    logic [CNT_W-1:0] changed_run   = '0;
    bit               high_res_mode = 1'b0;
    logic [7:0]       cooldown_left = '0;
    logic [7:0]       ignore_left   = STARTUP_IGNORE_RST;
    logic [7:0]       diff_thr      = DIFF_THR_RST;
    logic [CNT_W-1:0] count_thr     = CNT_W'(COUNT_THR_RST);
    logic [7:0]       cooldown_cfg  = COOLDOWN_RST;
    logic [7:0]       startup_cfg   = STARTUP_IGNORE_RST;
    logic [7:0]       revert_cfg    = REVERT_IGNORE_RST;

    frame_result_t pending_frames [$];
    script_row_t   script [$];
    int            mismatches     = 0;
    int            frames_checked = 0;
    int            samples_sent   = 0;
    int            quiet_cycles   = 0;
    int            stall_left     = 0;
    int            ready_calm     = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random idle length: mostly short, a few long
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // value at distance d from old, either direction that fits, else a random value
    function automatic logic [7:0] near_value(input logic [7:0] old, input int d);
        int up;
        int dn;
        up = int'(old) + d;
        dn = int'(old) - d;
        if (up <= 255 && (dn < 0 || $urandom_range(0, 1) == 1))
            return up[7:0];
        if (dn >= 0)
            return dn[7:0];
        return 8'($urandom_range(0, 255));
    endfunction

    // advance the detector by one sample; returns 1 with the frame result on frame end
    function automatic bit detect_motion(input logic [7:0] smp, input logic last,
                                         output frame_result_t res);
        bit         comparing;
        logic [7:0] old;
        logic [7:0] dif;
        comparing = primed && !high_res_mode;
        res = '0;
        // per-cell compare and store, extra samples dropped
        if (cell_pos < CELLS)
        begin
            if (comparing)
            begin
                old = cell_store[cell_pos];
                dif = (smp > old) ? smp - old : old - smp;
                if (dif > diff_thr)
                    changed_run++;
                cell_store[cell_pos] = smp;
            end
            cell_pos++;
        end
        if (!last)
            return 1'b0;
        // per-frame decision and mode update
        res.changed_cells = comparing ? changed_run : '0;
        res.motion        = comparing && (changed_run > count_thr);
        res.send_frame    = 1'b1;
        if (ignore_left != 0)
        begin
            ignore_left--;
            res.ignoring = 1'b1;
            primed       = 1'b1;
        end
        else if (!high_res_mode)
        begin
            if (res.motion)
            begin
                high_res_mode  = 1'b1;
                cooldown_left  = cooldown_cfg;
                res.send_frame = 1'b0;
            end
            primed = 1'b1;
        end
        else if (cooldown_left <= 1)
        begin
            cooldown_left = '0;
            high_res_mode = 1'b0;
            ignore_left   = revert_cfg;
        end
        else
        begin
            cooldown_left--;
        end
        res.high_res = high_res_mode;
        cell_pos     = 0;
        changed_run  = '0;
        return 1'b1;
    endfunction

    function automatic script_row_t item_row(input logic [7:0] smp, input logic last,
                                             input bit typed, input logic m,
                                             input logic [CNT_W-1:0] c, input logic ig);
        script_row_t row;
        row        = '{default: '0};
        row.smp    = smp;
        row.last   = last;
        row.typed  = typed;
        row.want   = '{m, c, 1'b0, 1'b1, ig};
        return row;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] val);
        script_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("frame %0d: %s got %0d expected %0d", frames_checked, what, got, want);
    endtask

    // drive one sample item and wait for its handshake
    task automatic send_sample(input logic [7:0] smp, input logic last, input bit calm,
                               input bit typed, input frame_result_t typed_res);
        frame_result_t res;
        int            gap;
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= smp;
        in_ch.frame_end <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (detect_motion(smp, last, res))
            pending_frames.push_back(typed ? typed_res : res);
        samples_sent++;
        gap = (calm || $urandom_range(0, 99) < 65) ? 0 : gap_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let every pending frame result out, then wait out the settle time
    task automatic wait_idle(input int settle);
        in_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_idle(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DIFF_THR:       diff_thr     = val[7:0];
            CFG_COUNT_THR:      count_thr    = val[CNT_W-1:0];
            CFG_COOLDOWN:       cooldown_cfg = val[7:0];
            CFG_STARTUP_IGNORE: startup_cfg  = val[7:0];
            CFG_REVERT_IGNORE:  revert_cfg   = val[7:0];
            default: ;
        endcase
    endtask

    // result ready with random stalls and calm stretches
    always @(posedge clk)
    begin
        if (ready_calm > 0)
            ready_calm <= ready_calm - 1;
        else if ($urandom_range(0, 299) == 0)
            ready_calm <= $urandom_range(50, 300);
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (ready_calm == 0 && $urandom_range(0, 99) < 25)
        begin
            stall_left   <= gap_length() - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.motion, out_ch.changed_cells, out_ch.high_res,
                    out_ch.send_frame, out_ch.ignoring};
            if (pending_frames.size() == 0)
            begin
                report_mismatch("result with no frame pending", int'(got), 0);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got.motion !== want.motion)
                    report_mismatch("motion", int'(got.motion), int'(want.motion));
                if (got.changed_cells !== want.changed_cells)
                    report_mismatch("changed_cells", int'(got.changed_cells),
                                    int'(want.changed_cells));
                if (got.high_res !== want.high_res)
                    report_mismatch("high_res", int'(got.high_res), int'(want.high_res));
                if (got.send_frame !== want.send_frame)
                    report_mismatch("send_frame", int'(got.send_frame),
                                    int'(want.send_frame));
                if (got.ignoring !== want.ignoring)
                    report_mismatch("ignoring", int'(got.ignoring), int'(want.ignoring));
            end
            frames_checked++;
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int               ph;
        int               target;
        int               phase_frames;
        int               len;
        int               strong_pct;
        int               pick;
        bit               calm;
        logic [7:0]       old;
        logic [7:0]       smp;
        logic [CFG_W-1:0] v_diff;
        logic [CFG_W-1:0] v_count;
        logic [CFG_W-1:0] v_cool;
        logic [CFG_W-1:0] v_start;
        logic [CFG_W-1:0] v_revert;

        // known values on the driven inputs from time zero; result ready
        // comes from its own clocked block
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample    = '0;
        in_ch.frame_end = 1'b0;
        foreach (cell_store[i])
            cell_store[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: unprimed frame, then the startup ignore window
        script.push_back(item_row(8'd0,   1'b1, 1'b1, 1'b0, 9'd0, 1'b1));
        script.push_back(item_row(8'd255, 1'b1, 1'b1, 1'b0, 9'd1, 1'b1));
        // difference equal to the threshold, then one above
        script.push_back(item_row(8'd240, 1'b1, 1'b1, 1'b0, 9'd0, 1'b1));
        script.push_back(item_row(8'd224, 1'b1, 1'b1, 1'b0, 9'd1, 1'b1));
        // short frame of three cells
        script.push_back(item_row(8'd224, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0));
        script.push_back(item_row(8'd255, 1'b0, 1'b0, 1'b0, 9'd0, 1'b0));
        script.push_back(item_row(8'd0,   1'b1, 1'b1, 1'b0, 9'd1, 1'b1));
        // rest of the startup window
        script.push_back(item_row(8'd0,   1'b1, 1'b1, 1'b0, 9'd1, 1'b1));
        script.push_back(item_row(8'd0,   1'b1, 1'b1, 1'b0, 9'd0, 1'b1));
        script.push_back(item_row(8'd16,  1'b1, 1'b1, 1'b0, 9'd1, 1'b1));
        script.push_back(item_row(8'd31,  1'b1, 1'b1, 1'b0, 9'd0, 1'b1));
        script.push_back(item_row(8'd255, 1'b1, 1'b1, 1'b0, 9'd1, 1'b1));
        // trigger on one cell with zero cooldown and a one-frame revert window
        script.push_back(cfg_row(CFG_COUNT_THR, '0));
        script.push_back(cfg_row(CFG_COOLDOWN, '0));
        script.push_back(cfg_row(CFG_REVERT_IGNORE, CFG_W'(1)));
        script.push_back(item_row(8'd0,   1'b1, 1'b0, 1'b0, 9'd0, 1'b0));
        script.push_back(item_row(8'd128, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0));
        script.push_back(item_row(8'd200, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0));
        script.push_back(item_row(8'd200, 1'b1, 1'b0, 1'b0, 9'd0, 1'b0));

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_sample(script[i].smp, script[i].last, 1'b0, script[i].typed,
                            script[i].want);
        end

        // random phases, each with its own register setting
        for (ph = 0; ph < 3 || samples_sent < ITEMS_GOAL; ph++)
        begin
            case (ph)
                0:
                begin
                    v_diff   = CFG_W'(0);
                    v_count  = CFG_W'(256);
                    v_cool   = CFG_W'(1);
                    v_start  = CFG_W'(255);
                    v_revert = CFG_W'(0);
                end
                1:
                begin
                    v_diff   = CFG_W'(255);
                    v_count  = CFG_W'(0);
                    v_cool   = CFG_W'(2);
                    v_start  = CFG_W'(0);
                    v_revert = CFG_W'(3);
                end
                2:
                begin
                    v_diff   = CFG_W'(20);
                    v_count  = CFG_W'(5);
                    v_cool   = CFG_W'(4);
                    v_start  = CFG_W'(17);
                    v_revert = CFG_W'(2);
                end
                default:
                begin
                    v_diff   = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, 40));
                    v_count  = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 256)
                                                                 : $urandom_range(0, 40));
                    v_cool   = CFG_W'($urandom_range(0, 5));
                    v_start  = CFG_W'($urandom_range(0, 255));
                    v_revert = CFG_W'($urandom_range(0, 3));
                end
            endcase
            write_reg(CFG_DIFF_THR, v_diff);
            write_reg(CFG_COUNT_THR, v_count);
            write_reg(CFG_COOLDOWN, v_cool);
            write_reg(CFG_STARTUP_IGNORE, v_start);
            write_reg(CFG_REVERT_IGNORE, v_revert);

            // run until the phase's frames are done and the mode is back to sentry
            target       = $urandom_range(3, 6);
            phase_frames = 0;
            while (phase_frames < target || high_res_mode || ignore_left != 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                // one full grid plus extra samples in a compared frame
                if (ph == 2 && phase_frames == 0)
                begin
                    len = CELLS + 20;
                end
                // frames that are not compared mostly stay short
                else if ((high_res_mode || ignore_left != 0) && $urandom_range(0, 19) != 0)
                begin
                    len = $urandom_range(1, 16);
                end
                else
                begin
                    pick = $urandom_range(0, 39);
                    len  = (pick == 0) ? CELLS :
                           (pick == 1) ? $urandom_range(CELLS + 1, CELLS + 44) :
                                         $urandom_range(1, 32);
                end
                case ($urandom_range(0, 4))
                    0:       strong_pct = 0;
                    1:       strong_pct = 3;
                    2:       strong_pct = 50;
                    3:       strong_pct = 100;
                    default: strong_pct = $urandom_range(0, 100);
                endcase
                // cell content: large change, same value, near the difference threshold or random
                for (int k = 0; k < len; k++)
                begin
                    old = (k < CELLS) ? cell_store[k] : 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 99) < strong_pct)
                    begin
                        smp = old[7] ? 8'd0 : 8'd255;
                    end
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0:       smp = old;
                            1:       smp = near_value(old, int'(diff_thr));
                            2:       smp = near_value(old, int'(diff_thr) + 1);
                            default: smp = 8'($urandom_range(0, 255));
                        endcase
                    end
                    send_sample(smp, k == len - 1, calm, 1'b0, '0);
                end
                phase_frames++;
            end
        end

        // drain and finish
        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
